FILE: design/oaht_pkg.sv
// Package: shared types, constants and hash parameters for the hash table.
`default_nettype none
package oaht_pkg;
  localparam int CAPACITY   = 8192;
  localparam int KEY_BYTES  = 5;
  localparam int VALUE_BITS = 32;
  localparam int SLOT_W     = 13;
  localparam int SIZE_W     = 14;
  localparam int KEY_W      = 8 * KEY_BYTES;

  localparam logic [31:0] SEED_HOME = 32'h1234_5678;
  localparam logic [31:0] SEED_STEP = 32'h8765_4321;
  localparam logic [31:0] MUR_MULT  = 32'h5bd1_e995;
  localparam int          MUR_SHIFT = 15;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USED  = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_MISS  = 2'd1;
  localparam logic [1:0] RES_FULL  = 2'd2;
  localparam logic [1:0] RES_LIMIT = 2'd3;

  localparam logic [1:0] REG_SIZE  = 2'd0;
  localparam logic [1:0] REG_MODE  = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_MULHI, S_MOD, S_CHECK, S_READ, S_EVAL, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;     // write empty into sweep slot
    logic load;         // capture item, start hashes
    logic hash_step;    // xor in one key byte, start its multiply
    logic mul_step;     // finish multiply half
    logic mod_start;
    logic mod_step;
    logic limit_check;
    logic rd;           // issue slot read
    logic eval;         // evaluate slot, advance
    logic finish;       // present result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic hash_done;
    logic mod_done;
    logic over_limit;
    logic probe_stop;   // evaluation ends the probe
  } dp_sts_t;
endpackage
`default_nettype wire

FILE: design/open_address_hash_table.sv
// Top level: open-addressed hash table with controller and datapath.
//
//  channel | handshake          | payload
//  in_     | start & !busy      | in_action, in_key, in_value
//  out_    | out_valid (1 cycle)| out_status, out_found_value, out_slot
//  cfg_    | cfg_valid&cfg_ready| cfg_index, cfg_data
//
// After reset a clearing pass sweeps all 8192 status entries, one per cycle;
// busy stays high for the whole pass. Per item: each key byte is hashed in a
// low-half and a high-half multiply step, and a final pass sees the key end;
// a restoring divider then reduces both hashes in shared steps, a limit check
// runs, each probed slot is read (registered) and then evaluated, and a result
// is presented. The receiver cannot stall results.
`default_nettype none
module open_address_hash_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [39:0] in_key,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_found_value,
  output logic [12:0]      out_slot,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import oaht_pkg::*;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // registers accept writes at any time
  assign cfg_ready = 1'b1;

  oaht_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .cmd, .sts
  );

  oaht_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_action, .in_key, .in_value,
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
    .out_valid, .out_status, .out_found_value, .out_slot
  );
endmodule
`default_nettype wire

FILE: design/oaht_ctrl.sv
// Controller: sequences clear, hash, modulo and probe steps.
`default_nettype none
module oaht_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  output oaht_pkg::dp_cmd_t     cmd,
  input  wire oaht_pkg::dp_sts_t sts
);
  import oaht_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        state_nxt = S_MULHI;
      end
      S_MULHI: begin
        cmd.mul_step = 1'b1;
        if (sts.hash_done) begin
          cmd.mod_start = 1'b1;
          state_nxt = S_MOD;
        end else state_nxt = S_HASH;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.limit_check = 1'b1;
        if (sts.over_limit) state_nxt = S_DONE;
        else state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.probe_stop) state_nxt = S_DONE;
        else state_nxt = S_READ;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: design/oaht_dp.sv
// Datapath: hashing, modulo unit, slot stores and probe arithmetic.
`default_nettype none
module oaht_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire oaht_pkg::dp_cmd_t              cmd,
  output oaht_pkg::dp_sts_t                   sts,
  input  wire logic [1:0]                     in_action,
  input  wire logic [oaht_pkg::KEY_W-1:0]     in_key,
  input  wire logic [oaht_pkg::VALUE_BITS-1:0] in_value,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_idx,
  input  wire logic [31:0]                    cfg_wdata,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [oaht_pkg::VALUE_BITS-1:0]     out_found_value,
  output logic [oaht_pkg::SLOT_W-1:0]         out_slot
);
  import oaht_pkg::*;

  // configuration
  logic [SIZE_W-1:0] size_r;
  logic              mode_r;
  logic [9:0]        limit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(6101);
      mode_r <= 1'b0;
      limit_r <= 10'd1000;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SIZE:  size_r <= cfg_wdata[SIZE_W-1:0];
        REG_MODE:  mode_r <= cfg_wdata[0];
        REG_LIMIT: limit_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] m_r;   // effective size latched per item
  logic [SIZE_W-1:0] m_eff;
  always_comb begin
    if (size_r < SIZE_W'(2)) m_eff = SIZE_W'(2);
    else if (size_r > SIZE_W'(CAPACITY)) m_eff = SIZE_W'(CAPACITY);
    else m_eff = size_r;
  end

  // item registers
  logic [1:0]            act_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [KEY_BYTES-1:0]  keep;
  logic [KEY_W-1:0]      tkey;
  always_comb begin
    tkey = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      keep[b] = (in_key[KEY_W-1-8*b -: 8] != 8'd0) && (b == 0 || keep[b-1]);
      if (keep[b]) tkey[KEY_W-1-8*b -: 8] = in_key[KEY_W-1-8*b -: 8];
    end
  end

  // hash: two 32-bit states, multiply split in 16-bit halves (hash step, then high-half step)
  logic [31:0] h1_r, h2_r, x1_r, x2_r, p1_r, p2_r;
  logic [2:0]  bidx_r;
  logic [7:0]  cur_byte;
  logic        hash_more;
  assign cur_byte = key_r[KEY_W-1-8*bidx_r -: 8];
  assign hash_more = (32'(bidx_r) < KEY_BYTES) && (cur_byte != 8'd0);

  logic [31:0] x1c, x2c, f1, f2;
  always_comb begin
    x1c = h1_r ^ {24'd0, cur_byte};
    x2c = h2_r ^ {24'd0, cur_byte};
    f1 = p1_r + {x1_r[15:0] * MUR_MULT[31:16], 16'd0};
    f2 = p2_r + {x2_r[15:0] * MUR_MULT[31:16], 16'd0};
    f1 = f1 ^ (f1 >> MUR_SHIFT);
    f2 = f2 ^ (f2 >> MUR_SHIFT);
  end

  // restoring divider: 32-bit dividend by up to 14-bit divisor, both at once
  logic [31:0] q1_r, q2_r;
  logic [SIZE_W:0] r1_r, r2_r;
  logic [5:0] dcnt_r;
  logic [SIZE_W-1:0] d2;
  assign d2 = m_r - SIZE_W'(1);
  logic [SIZE_W+1:0] t1, t2;
  always_comb begin
    t1 = {r1_r, q1_r[31]};
    t2 = {r2_r, q2_r[31]};
  end

  // probe state
  logic [SLOT_W-1:0] pos_r, step_r;
  logic [SIZE_W-1:0] cnt_r;
  logic [SIZE_W-1:0] entries_r;

  // stores
  logic [1:0]            st_mem [CAPACITY];
  logic [KEY_W-1:0]      key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [1:0]            st_q;
  logic [KEY_W-1:0]      key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [SLOT_W-1:0]     clr_r;

  logic st_we, key_we;
  logic [1:0] st_wd;
  logic [SLOT_W-1:0] waddr;
  logic hit, ins_take, stop, exhausted;
  logic [SIZE_W:0] nsum;
  logic [SLOT_W-1:0] npos;

  always_comb begin
    hit = (st_q == ST_USED) && (key_q == key_r);
    ins_take = (st_q != ST_USED);
    exhausted = (cnt_r + SIZE_W'(1) == m_r);
    if (act_r == ACT_INSERT) stop = ins_take || exhausted;
    else stop = (st_q == ST_EMPTY) || hit || exhausted;
    nsum = {2'b0, pos_r} + {2'b0, step_r};
    if (nsum >= {1'b0, m_r}) nsum = nsum - {1'b0, m_r};
    npos = nsum[SLOT_W-1:0];
    st_we = 1'b0; key_we = 1'b0; st_wd = ST_EMPTY; waddr = pos_r;
    if (cmd.clr_step) begin
      st_we = 1'b1; waddr = clr_r;
    end else if (cmd.eval && act_r == ACT_INSERT && ins_take) begin
      st_we = 1'b1; key_we = 1'b1; st_wd = ST_USED;
    end else if (cmd.eval && act_r == ACT_REMOVE && hit) begin
      st_we = 1'b1; st_wd = ST_TOMB;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[waddr] <= st_wd;
    if (key_we) begin
      key_mem[waddr] <= key_r;
      val_mem[waddr] <= val_r;
    end
    if (cmd.rd) begin
      st_q <= st_mem[pos_r];
      key_q <= key_mem[pos_r];
      val_q <= val_mem[pos_r];
    end
  end

  logic [25:0] need, allow;
  logic        over_c;
  assign need = 26'({entries_r + SIZE_W'(1)} * 26'd1000);
  assign allow = 26'(limit_r) * 26'(m_r);

  // end the item before probing: insert over the limit, or an unknown action
  always_comb begin
    if (act_r == ACT_INSERT) over_c = (need > allow);
    else over_c = !(act_r == ACT_SEARCH || act_r == ACT_REMOVE);
  end

  assign sts.clr_last = (clr_r == SLOT_W'(CAPACITY - 1));
  assign sts.hash_done = !hash_more;
  assign sts.mod_done = (dcnt_r == 6'd31);
  assign sts.probe_stop = stop;
  assign sts.over_limit = over_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      entries_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cmd.clr_step) clr_r <= clr_r + SLOT_W'(1);
      if (cmd.load) begin
        act_r <= in_action; key_r <= tkey; val_r <= in_value;
        m_r <= m_eff; h1_r <= SEED_HOME; h2_r <= SEED_STEP; bidx_r <= '0;
        out_status <= RES_MISS; out_found_value <= '0; out_slot <= '0;
      end
      if (cmd.hash_step && hash_more) begin
        x1_r <= x1c; x2_r <= x2c;
        p1_r <= x1c * {16'd0, MUR_MULT[15:0]};
        p2_r <= x2c * {16'd0, MUR_MULT[15:0]};
      end
      if (cmd.mul_step && hash_more) begin
        h1_r <= f1; h2_r <= f2; bidx_r <= bidx_r + 3'd1;
      end
      if (cmd.mod_start) begin
        q1_r <= h1_r; q2_r <= h2_r; r1_r <= '0; r2_r <= '0; dcnt_r <= '0;
      end
      if (cmd.mod_step) begin
        dcnt_r <= dcnt_r + 6'd1;
        q1_r <= {q1_r[30:0], 1'b0}; q2_r <= {q2_r[30:0], 1'b0};
        if (t1 >= {2'b0, m_r}) r1_r <= (SIZE_W+1)'(t1 - {2'b0, m_r});
        else r1_r <= t1[SIZE_W:0];
        if (t2 >= {2'b0, d2}) r2_r <= (SIZE_W+1)'(t2 - {2'b0, d2});
        else r2_r <= t2[SIZE_W:0];
      end
      if (cmd.limit_check) begin
        pos_r <= r1_r[SLOT_W-1:0];
        step_r <= mode_r ? SLOT_W'(r2_r + 1'b1) : SLOT_W'(1);
        cnt_r <= '0;
        if (act_r == ACT_INSERT && need > allow) out_status <= RES_LIMIT;
      end
      if (cmd.eval) begin
        pos_r <= npos;
        cnt_r <= cnt_r + SIZE_W'(1);
        if (act_r == ACT_INSERT) begin
          if (ins_take) begin
            out_status <= RES_OK; out_slot <= pos_r;
            entries_r <= entries_r + SIZE_W'(1);
          end else if (exhausted) out_status <= RES_FULL;
        end else if (hit) begin
          out_status <= RES_OK; out_slot <= pos_r; out_found_value <= val_q;
          if (act_r == ACT_REMOVE && entries_r != '0)
            entries_r <= entries_r - SIZE_W'(1);
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: tb/open_address_hash_table_check.sv
// Checker: watches the hash table's channels, predicts each lookup result and compares it.
`default_nettype none
module open_address_hash_table_check
  import oaht_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [39:0] in_key,
  input  wire logic [31:0] in_value,
  input  wire logic        out_valid,
  input  wire logic [1:0]  out_status,
  input  wire logic [31:0] out_found_value,
  input  wire logic [12:0] out_slot,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [12:0] slot;
  } lookup_t;

  lookup_t             lookup_q[$];
  logic [SIZE_W-1:0]   size_reg;
  logic                mode_reg;
  logic [9:0]          limit_reg;
  logic [1:0]          slot_state[CAPACITY];
  logic [KEY_W-1:0]    slot_keys[CAPACITY];
  logic [31:0]         slot_vals[CAPACITY];
  int unsigned         live_entries;

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Key bytes after the first zero byte drop out of hashing and compares.
  function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] t;
    t = '0;
    for (int b = KEY_BYTES - 1; b >= 0; b--) begin
      if (k[8*b +: 8] == 8'h00) break;
      t[8*b +: 8] = k[8*b +: 8];
    end
    return t;
  endfunction

  function automatic logic [31:0] murmur(input logic [KEY_W-1:0] k, input logic [31:0] seed);
    logic [31:0] h;
    h = seed;
    for (int b = KEY_BYTES - 1; b >= 0; b--) begin
      if (k[8*b +: 8] == 8'h00) break;
      h = h ^ {24'd0, k[8*b +: 8]};
      h = h * MUR_MULT;
      h = h ^ (h >> MUR_SHIFT);
    end
    return h;
  endfunction

  // Run one table operation on the shadow table and return its result.
  function automatic lookup_t table_op(input logic [1:0] act, input logic [39:0] raw_key,
                                       input logic [31:0] val);
    lookup_t           r;
    logic [KEY_W-1:0]  k;
    int unsigned       m, pos, stride;
    longint unsigned   need, allow;
    r = '{status: RES_MISS, found_value: '0, slot: '0};
    k = trim_key(raw_key);
    m = (size_reg < 2) ? 2 : (size_reg > CAPACITY) ? CAPACITY : size_reg;
    pos = murmur(k, SEED_HOME) % m;
    stride = mode_reg ? (murmur(k, SEED_STEP) % (m - 1)) + 1 : 1;
    if (act == ACT_INSERT) begin
      need  = (longint'(live_entries) + 1) * 1000;
      allow = longint'(limit_reg) * m;
      if (need > allow) begin
        r.status = RES_LIMIT;
      end else begin
        r.status = RES_FULL;
        for (int i = 0; i < m; i++) begin
          if (slot_state[pos] != ST_USED) begin
            slot_state[pos] = ST_USED;
            slot_keys[pos]  = k;
            slot_vals[pos]  = val;
            live_entries++;
            r.status = RES_OK;
            r.slot   = pos[12:0];
            break;
          end
          pos = (pos + stride) % m;
        end
      end
    end else if (act == ACT_SEARCH || act == ACT_REMOVE) begin
      for (int i = 0; i < m; i++) begin
        if (slot_state[pos] == ST_EMPTY) break;
        if (slot_state[pos] == ST_USED && slot_keys[pos] == k) begin
          r.status      = RES_OK;
          r.found_value = slot_vals[pos];
          r.slot        = pos[12:0];
          if (act == ACT_REMOVE) begin
            slot_state[pos] = ST_TOMB;
            if (live_entries > 0) live_entries--;
          end
          break;
        end
        pos = (pos + stride) % m;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (!rst_n) begin
      size_reg     = 14'd6101;
      mode_reg     = 1'b0;
      limit_reg    = 10'd1000;
      live_entries = 0;
      foreach (slot_state[i]) slot_state[i] = ST_EMPTY;
      lookup_q.delete();
    end else begin
      if (out_valid) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("unexpected result slot", out_slot, '0);
        end else begin
          want = lookup_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_found_value !== want.found_value)
            report_mismatch("found_value", out_found_value, want.found_value);
          if (out_slot !== want.slot)
            report_mismatch("slot", out_slot, want.slot);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIZE:  size_reg  = cfg_data[SIZE_W-1:0];
          REG_MODE:  mode_reg  = cfg_data[0];
          REG_LIMIT: limit_reg = cfg_data[9:0];
          default: ;
        endcase
      end
      if (start && !busy) lookup_q.push_back(table_op(in_action, in_key, in_value));
    end
    results_owed <= lookup_q.size();
  end

  final begin
    if (lookup_q.size() != 0)
      $display("%0d expected results never arrived", lookup_q.size());
  end
endmodule
`default_nettype wire

FILE: tb/open_address_hash_table_test.sv
// Testbench top: drives the hash table, runs configuration phases and gives the verdict.
`default_nettype none
module open_address_hash_table_test;
  import oaht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 100000;  // clearing pass plus a full-table probe, many times over

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = ACT_SEARCH;
  logic [39:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_found_value;
  logic [12:0] out_slot;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_SIZE;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          results_owed;
  int          stall_cycles = 0;
  bit          steady = 1'b0;       // set for the final phase: no idle bursts
  logic [39:0] key_pool[10];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  open_address_hash_table u_top (
    .clk, .rst_n, .start, .busy, .in_action, .in_key, .in_value,
    .out_valid, .out_status, .out_found_value, .out_slot,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  open_address_hash_table_check u_check (
    .clk, .rst_n, .start, .busy, .in_action, .in_key, .in_value,
    .out_valid, .out_status, .out_found_value, .out_slot,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .results_owed
  );

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("open_address_hash_table_test: FAIL");
        $finish;
      end
    end
  end

  // Hold one lookup on the input until it transfers, then maybe drop start for a burst.
  task automatic send_op(input logic [1:0] act, input logic [39:0] k, input logic [31:0] v);
    int gap;
    gap = 0;
    start     <= 1'b1;
    in_action <= act;
    in_key    <= k;
    in_value  <= v;
    do @(posedge clk); while (busy);
    if (!steady && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain: drop start and wait until every owed result has come back.
  task automatic settle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; junk above the register width must be ignored.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val, input int width);
    logic [31:0] mask;
    mask = (32'd1 << width) - 1;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ($urandom & ~mask) | (val & mask);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (!steady && $urandom_range(0, 1) == 0) repeat ($urandom_range(1, 9)) @(posedge clk);
    else @(posedge clk);
  endtask

  task automatic set_table(input int size, input int mode, input int limit);
    settle();
    write_reg(REG_SIZE, size, SIZE_W);
    write_reg(REG_MODE, mode, 1);
    write_reg(REG_LIMIT, limit, 10);
  endtask

  // Fresh key: bytes are often zero (ending the key early) or all ones.
  function automatic logic [39:0] fresh_key();
    logic [39:0] k;
    for (int b = 0; b < 5; b++) begin
      case ($urandom_range(0, 9))
        0:       k[8*b +: 8] = 8'h00;
        1:       k[8*b +: 8] = 8'hff;
        default: k[8*b +: 8] = $urandom;
      endcase
    end
    return k;
  endfunction

  task automatic random_phase(input int size, input int mode, input int limit, input int count);
    int          r;
    logic [1:0]  act;
    logic [39:0] k;
    set_table(size, mode, limit);
    foreach (key_pool[i]) key_pool[i] = fresh_key();
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      act = (r < 40) ? ACT_INSERT : (r < 70) ? ACT_SEARCH : (r < 95) ? ACT_REMOVE : 2'd3;
      k = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 9)] : fresh_key();
      send_op(act, k, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Two-slot table: zero key, all-ones key, then a full table.
    set_table(2, 0, 1023);
    send_op(ACT_INSERT, 40'h00_0000_0000, 32'hffff_ffff);
    send_op(ACT_INSERT, 40'hff_ffff_ffff, 32'h0000_0000);
    send_op(ACT_INSERT, 40'h41_00aa_bbcc, 32'h0000_0001);
    send_op(ACT_SEARCH, 40'h41_0011_2233, 32'h0);
    send_op(ACT_SEARCH, 40'hff_ffff_ffff, 32'h0);
    send_op(ACT_REMOVE, 40'hff_ffff_ffff, 32'h0);
    // Tombstone is skipped on search and remove, reused on insert.
    send_op(ACT_SEARCH, 40'hff_ffff_ffff, 32'h0);
    send_op(ACT_REMOVE, 40'hff_ffff_ffff, 32'h0);
    send_op(ACT_INSERT, 40'h41_00aa_bbcc, 32'h8000_0000);
    send_op(ACT_SEARCH, 40'h41_0000_0000, 32'h0);
    send_op(2'd3, 40'h41_0000_0000, 32'hdead_beef);
    send_op(ACT_SEARCH, 40'h00_0000_0000, 32'h0);

    // Zero limit refuses every insert.
    set_table(2, 1, 0);
    send_op(ACT_INSERT, 40'h12_3456_789a, 32'h5555_5555);

    // Double hashing with duplicate inserts of one key.
    set_table(61, 1, 1000);
    send_op(ACT_INSERT, 40'h12_3456_789a, 32'haaaa_aaaa);
    send_op(ACT_INSERT, 40'h12_3456_789a, 32'h5555_5555);
    send_op(ACT_SEARCH, 40'h12_3456_789a, 32'h0);
    send_op(ACT_REMOVE, 40'h12_3456_789a, 32'h0);
    send_op(ACT_SEARCH, 40'h12_3456_789a, 32'h0);
    send_op(ACT_REMOVE, 40'h12_3456_789a, 32'h0);

    random_phase(16, 0, 1000, 60);
    random_phase(16, 1, 750, 60);
    random_phase(61, 1, 1023, 55);
    random_phase(3, 1, 900, 40);
    random_phase(0, 0, 1000, 30);        // below two acts as two
    random_phase(16383, 1, 500, 20);     // above capacity acts as capacity
    random_phase(8192, 0, 1, 15);
    random_phase(1, 1, 1000, 25);
    steady = 1'b1;
    random_phase(200, 1, 1000, 60);

    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("open_address_hash_table_test: PASS");
    end else begin
      $display("open_address_hash_table_test: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
